// ----- hw/rtl/rfc_pkg.sv -----
// Shared constants, command codes, queue entry and result types of the rectangle-fill canvas.
package rfc_pkg;

    // Canvas geometry and field widths.
    localparam int CANVAS_SIDE = 128;
    localparam int PIXELS      = CANVAS_SIDE * CANVAS_SIDE;
    localparam int ADDR_W      = $clog2(PIXELS);
    localparam int XY_W        = 7;
    localparam int EXT_W       = 8;
    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 40;

    localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 24'hFF_FFFF;

    // Command codes carried in the lowest bits of an input transfer.
    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        cmd_t                cmd;
        logic [XY_W-1:0]     left;
        logic [XY_W-1:0]     top;
        logic [EXT_W-1:0]    right;     // clipped left plus width, also the column reach
        logic [EXT_W-1:0]    bottom;    // clipped top plus height, also the row reach
        logic                in_range;  // read coordinate lies on the canvas
        logic [PIXEL_W-1:0]  colour;
    } op_t;

    // One result; the first field sits in the highest bits.
    typedef struct packed {
        logic [EXT_W-1:0]  used_columns;
        logic [EXT_W-1:0]  used_rows;
        logic [CHAN_W-1:0] pixel_blue;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_red;
    } res_t;

    // Execution states of the back end.
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DRAW,
        ST_READ
    } back_state_t;

    // Status that the back end reports to the front end.
    typedef struct packed {
        logic init_busy;
    } back_status_t;

    // Origin plus size, clipped at the canvas side.
    function automatic logic [EXT_W-1:0] clip_reach(input logic [XY_W-1:0] origin,
                                                    input logic [EXT_W-1:0] size);
        logic [EXT_W:0] sum;
        sum = (EXT_W+1)'(origin) + (EXT_W+1)'(size);
        if (sum > (EXT_W+1)'(CANVAS_SIDE))
            return EXT_W'(CANVAS_SIDE);
        else
            return sum[EXT_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rectangle_fill_canvas.sv -----
// Throughput: one pixel per cycle, set by the single write port of the canvas memory;
// commands run one at a time while a two-entry queue keeps taking new transfers.
// Reset: asynchronous, active low; afterwards a pass whitens the canvas,
// one pixel per cycle, and no input transfer is taken until it ends.
module rectangle_fill_canvas
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command, column_x, row_y, width, height, red, green, blue
    input  logic [rfc_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_red, pixel_green, pixel_blue, used_rows, used_columns
    output logic [rfc_pkg::OUT_DATA_W-1:0] m_tdata
);

    rfc_pkg::back_status_t status;
    rfc_pkg::op_t          push_op;
    rfc_pkg::op_t          head_op;
    logic                  q_push;
    logic                  q_ready;
    logic                  q_pop;
    logic                  q_valid;

    // Decode and clip incoming commands.
    rfc_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .status   (status),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    // Queue between decode and execution.
    rfc_cmd_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (head_op)
    );

    // Execute against the canvas and deliver results.
    rfc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_op     (head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule

// ----- hw/rtl/rfc_front.sv -----
// Front end: takes input transfers, decodes and clips them into queue entries.
module rfc_front
(
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command, column_x, row_y, width, height, red, green, blue
    input  logic [rfc_pkg::IN_DATA_W-1:0] s_tdata,
    input  rfc_pkg::back_status_t         status,
    input  logic                          q_ready,
    output logic                          q_push,
    output rfc_pkg::op_t                  q_op
);

    logic [1:0]                  command;
    logic [rfc_pkg::XY_W-1:0]    column_x;
    logic [rfc_pkg::XY_W-1:0]    row_y;
    logic [rfc_pkg::EXT_W-1:0]   width;
    logic [rfc_pkg::EXT_W-1:0]   height;
    logic [rfc_pkg::CHAN_W-1:0]  red;
    logic [rfc_pkg::CHAN_W-1:0]  green;
    logic [rfc_pkg::CHAN_W-1:0]  blue;

    // Unpack the fields.
    assign command  = s_tdata[1:0];
    assign column_x = s_tdata[8:2];
    assign row_y    = s_tdata[15:9];
    assign width    = s_tdata[23:16];
    assign height   = s_tdata[31:24];
    assign red      = s_tdata[39:32];
    assign green    = s_tdata[47:40];
    assign blue     = s_tdata[55:48];

    // Nothing is taken while the power-up clearing pass runs.
    assign s_tready = q_ready && !status.init_busy;
    assign q_push   = s_tvalid && s_tready;

    // Classify and clip the command.
    always_comb
    begin
        q_op.cmd      = rfc_pkg::cmd_t'(command);
        q_op.left     = column_x;
        q_op.top      = row_y;
        q_op.right    = rfc_pkg::clip_reach(column_x, width);
        q_op.bottom   = rfc_pkg::clip_reach(row_y, height);
        q_op.in_range = (rfc_pkg::EXT_W'(column_x) < rfc_pkg::EXT_W'(rfc_pkg::CANVAS_SIDE))
                     && (rfc_pkg::EXT_W'(row_y) < rfc_pkg::EXT_W'(rfc_pkg::CANVAS_SIDE));
        q_op.colour   = {red, green, blue};
    end

endmodule

// ----- hw/rtl/rfc_cmd_fifo.sv -----
// Two-entry queue of decoded commands between the front and back ends.
module rfc_cmd_fifo
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  rfc_pkg::op_t push_op,
    output logic         ready,
    input  logic         pop,
    output logic         valid,
    output rfc_pkg::op_t head_op
);

    rfc_pkg::op_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head_op = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

// ----- hw/rtl/rfc_back.sv -----
// Back end: executes queued commands against the canvas memory and holds the result.
module rfc_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  rfc_pkg::op_t                   q_op,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_red, pixel_green, pixel_blue, used_rows, used_columns
    output logic [rfc_pkg::OUT_DATA_W-1:0] m_tdata,
    output rfc_pkg::back_status_t          status
);

    rfc_pkg::back_state_t          state_reg;
    rfc_pkg::back_state_t          state_next;
    rfc_pkg::op_t                  op_reg;
    logic [rfc_pkg::XY_W-1:0]      row_reg;
    logic [rfc_pkg::XY_W-1:0]      col_reg;
    logic [rfc_pkg::ADDR_W-1:0]    addr_reg;
    logic                          sweep_cmd_reg;
    logic [rfc_pkg::EXT_W-1:0]     ext_row_reg;
    logic [rfc_pkg::EXT_W-1:0]     ext_row_next;
    logic [rfc_pkg::EXT_W-1:0]     ext_col_reg;
    logic [rfc_pkg::EXT_W-1:0]     ext_col_next;
    logic [rfc_pkg::PIXEL_W-1:0]   rd_data_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    rfc_pkg::res_t                 out_reg;

    logic [rfc_pkg::PIXEL_W-1:0]   mem [rfc_pkg::PIXELS];
    logic                          mem_we;
    logic                          mem_re;
    logic [rfc_pkg::ADDR_W-1:0]    mem_addr;
    logic [rfc_pkg::PIXEL_W-1:0]   mem_wdata;

    logic                          out_free;
    logic                          head_empty_box;
    logic                          col_last;
    logic                          row_last;
    logic                          sweep_last;
    logic                          load_result;
    logic [rfc_pkg::PIXEL_W-1:0]   result_colour;

    function automatic logic [rfc_pkg::ADDR_W-1:0] pix_addr(input logic [rfc_pkg::XY_W-1:0] row,
                                                            input logic [rfc_pkg::XY_W-1:0] col);
        return rfc_pkg::ADDR_W'(rfc_pkg::ADDR_W'(row) * rfc_pkg::ADDR_W'(rfc_pkg::CANVAS_SIDE)
                                + rfc_pkg::ADDR_W'(col));
    endfunction

    // Conditions used by both the sequencer and the datapath.
    assign out_free       = !out_valid_reg || m_tready;
    assign head_empty_box = (q_op.right <= rfc_pkg::EXT_W'(q_op.left))
                         || (q_op.bottom <= rfc_pkg::EXT_W'(q_op.top));
    assign col_last       = (rfc_pkg::EXT_W'(col_reg) + rfc_pkg::EXT_W'(1)) == op_reg.right;
    assign row_last       = (rfc_pkg::EXT_W'(row_reg) + rfc_pkg::EXT_W'(1)) == op_reg.bottom;
    assign sweep_last     = (addr_reg == rfc_pkg::ADDR_W'(rfc_pkg::PIXELS - 1));

    assign status.init_busy = (state_reg == rfc_pkg::ST_SWEEP) && !sweep_cmd_reg;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rfc_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                    state_next = rfc_pkg::ST_IDLE;
            end
            rfc_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    unique case (q_op.cmd)
                        rfc_pkg::CMD_DRAW:
                            state_next = head_empty_box ? rfc_pkg::ST_IDLE : rfc_pkg::ST_DRAW;
                        rfc_pkg::CMD_READ:  state_next = rfc_pkg::ST_READ;
                        rfc_pkg::CMD_CLEAR: state_next = rfc_pkg::ST_SWEEP;
                        rfc_pkg::CMD_NOP:   state_next = rfc_pkg::ST_IDLE;
                        default:            state_next = rfc_pkg::ST_IDLE;
                    endcase
                end
            end
            rfc_pkg::ST_DRAW:
            begin
                if (col_last && row_last)
                    state_next = rfc_pkg::ST_IDLE;
            end
            rfc_pkg::ST_READ:
                state_next = rfc_pkg::ST_IDLE;
            default:
                state_next = rfc_pkg::ST_IDLE;
        endcase
    end

    // Memory port, queue pop and result load for each state.
    always_comb
    begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = addr_reg;
        mem_wdata     = op_reg.colour;
        load_result   = 1'b0;
        result_colour = '0;
        unique case (state_reg)
            rfc_pkg::ST_SWEEP:
            begin
                mem_we      = 1'b1;
                mem_wdata   = rfc_pkg::WHITE_PIXEL;
                load_result = sweep_last && sweep_cmd_reg;
            end
            rfc_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    mem_addr = pix_addr(q_op.top, q_op.left);
                    mem_re   = (q_op.cmd == rfc_pkg::CMD_READ) && q_op.in_range;
                    // Commands that touch no pixel answer at once.
                    load_result = (q_op.cmd == rfc_pkg::CMD_NOP)
                               || ((q_op.cmd == rfc_pkg::CMD_DRAW) && head_empty_box);
                end
            end
            rfc_pkg::ST_DRAW:
            begin
                mem_we      = 1'b1;
                mem_addr    = pix_addr(row_reg, col_reg);
                load_result = col_last && row_last;
            end
            rfc_pkg::ST_READ:
            begin
                load_result   = 1'b1;
                result_colour = op_reg.in_range ? rd_data_reg : '0;
            end
            default:
            begin
                load_result = 1'b0;
            end
        endcase
    end

    // Extents change when a draw or a clear leaves the queue.
    always_comb
    begin
        ext_row_next = ext_row_reg;
        ext_col_next = ext_col_reg;
        if (q_pop && (q_op.cmd == rfc_pkg::CMD_DRAW))
        begin
            if (q_op.bottom > ext_row_reg)
                ext_row_next = q_op.bottom;
            if (q_op.right > ext_col_reg)
                ext_col_next = q_op.right;
        end
        else if (q_pop && (q_op.cmd == rfc_pkg::CMD_CLEAR))
        begin
            ext_row_next = '0;
            ext_col_next = '0;
        end
    end

    // Output register hands the result over independently of the sequencer.
    always_comb
    begin
        if (load_result)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfc_pkg::ST_SWEEP;
            addr_reg      <= '0;
            sweep_cmd_reg <= 1'b0;
            ext_row_reg   <= '0;
            ext_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ext_row_reg   <= ext_row_next;
            ext_col_reg   <= ext_col_next;
            out_valid_reg <= out_valid_next;
            if (q_pop && (q_op.cmd == rfc_pkg::CMD_CLEAR))
            begin
                addr_reg      <= '0;
                sweep_cmd_reg <= 1'b1;
            end
            else if (state_reg == rfc_pkg::ST_SWEEP)
            begin
                addr_reg <= addr_reg + rfc_pkg::ADDR_W'(1);
            end
        end
    end

    // Rectangle walk and result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg  <= q_op;
            row_reg <= q_op.top;
            col_reg <= q_op.left;
        end
        else if (state_reg == rfc_pkg::ST_DRAW)
        begin
            if (col_last)
            begin
                col_reg <= op_reg.left;
                row_reg <= row_reg + rfc_pkg::XY_W'(1);
            end
            else
            begin
                col_reg <= col_reg + rfc_pkg::XY_W'(1);
            end
        end
        if (load_result)
        begin
            out_reg.pixel_red    <= result_colour[23:16];
            out_reg.pixel_green  <= result_colour[15:8];
            out_reg.pixel_blue   <= result_colour[7:0];
            out_reg.used_rows    <= ext_row_next;
            out_reg.used_columns <= ext_col_next;
        end
    end

    // Canvas memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |-> out_free)
        else $error("result loaded while output register still full");

    // Commands leave the queue only when the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == rfc_pkg::ST_IDLE))
        else $error("command popped while a command is executing");

    // The rectangle walk stays inside the clipped box.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rfc_pkg::ST_DRAW) |->
            ((rfc_pkg::EXT_W'(row_reg) < op_reg.bottom)
             && (rfc_pkg::EXT_W'(col_reg) < op_reg.right)))
        else $error("draw walk left the clipped rectangle");

    // Extents never pass the canvas side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ext_row_reg <= rfc_pkg::EXT_W'(rfc_pkg::CANVAS_SIDE))
        && (ext_col_reg <= rfc_pkg::EXT_W'(rfc_pkg::CANVAS_SIDE)))
        else $error("extent beyond canvas side");

    // A clear command produces its result when its sweep ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == rfc_pkg::ST_SWEEP) && sweep_last && sweep_cmd_reg) |=> m_tvalid)
        else $error("clear sweep ended without a result");

endmodule

// ----- dv/rectangle_fill_canvas_tb.sv -----
// Self-checking testbench for the rectangle-fill canvas: directed corners, random mix, back-to-back.
`timescale 1ns / 100ps

module rectangle_fill_canvas_tb;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int REPORT_LIMIT   = 10;

    // One command as it travels on s_tdata; the last member sits in the lowest bits.
    typedef struct packed {
        logic [rfc_pkg::CHAN_W-1:0] blue;
        logic [rfc_pkg::CHAN_W-1:0] green;
        logic [rfc_pkg::CHAN_W-1:0] red;
        logic [rfc_pkg::EXT_W-1:0]  height;
        logic [rfc_pkg::EXT_W-1:0]  width;
        logic [rfc_pkg::XY_W-1:0]   row_y;
        logic [rfc_pkg::XY_W-1:0]   column_x;
        rfc_pkg::cmd_t              command;
    } canvas_cmd_t;

    logic                           clk;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rfc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rfc_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the canvas and its extents.
    logic [rfc_pkg::PIXEL_W-1:0] canvas_shadow [rfc_pkg::PIXELS];
    int                          row_reach;
    int                          column_reach;

    rfc_pkg::res_t pending_results[$];
    int            error_count  = 0;
    int            result_count = 0;
    int            stall_cycles = 0;
    int            sink_hold;
    bit            steady;
    bit            drain_each;

    rectangle_fill_canvas i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle lengths: mostly a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 200);
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Applies one command to the shadow canvas and returns the result it must produce.
    function automatic rfc_pkg::res_t apply_to_canvas(input canvas_cmd_t op);
        int                          right;
        int                          bottom;
        logic [rfc_pkg::PIXEL_W-1:0] seen;
        rfc_pkg::res_t               res;
        seen = '0;
        case (op.command)
            rfc_pkg::CMD_DRAW:
            begin
                right  = op.column_x + op.width;
                bottom = op.row_y + op.height;
                if (right > rfc_pkg::CANVAS_SIDE)
                    right = rfc_pkg::CANVAS_SIDE;
                if (bottom > rfc_pkg::CANVAS_SIDE)
                    bottom = rfc_pkg::CANVAS_SIDE;
                // Clipped pixels are dropped, never wrapped into the next row.
                for (int r = op.row_y; r < bottom; r++)
                    for (int c = op.column_x; c < right; c++)
                        canvas_shadow[r * rfc_pkg::CANVAS_SIDE + c] = {op.red, op.green, op.blue};
                if (right > column_reach)
                    column_reach = right;
                if (bottom > row_reach)
                    row_reach = bottom;
            end
            rfc_pkg::CMD_READ:
            begin
                if (op.column_x < rfc_pkg::CANVAS_SIDE && op.row_y < rfc_pkg::CANVAS_SIDE)
                    seen = canvas_shadow[op.row_y * rfc_pkg::CANVAS_SIDE + op.column_x];
            end
            rfc_pkg::CMD_CLEAR:
            begin
                foreach (canvas_shadow[k])
                    canvas_shadow[k] = rfc_pkg::WHITE_PIXEL;
                row_reach    = 0;
                column_reach = 0;
            end
            default:
            begin
                // The spare code leaves everything as it is.
            end
        endcase
        res.pixel_red    = seen[23:16];
        res.pixel_green  = seen[15:8];
        res.pixel_blue   = seen[7:0];
        res.used_rows    = rfc_pkg::EXT_W'(row_reach);
        res.used_columns = rfc_pkg::EXT_W'(column_reach);
        return res;
    endfunction

    function automatic canvas_cmd_t make_cmd(input rfc_pkg::cmd_t c, input int x, input int y,
                                             input int w, input int h,
                                             input logic [rfc_pkg::PIXEL_W-1:0] colour);
        canvas_cmd_t op;
        op.command  = c;
        op.column_x = rfc_pkg::XY_W'(x);
        op.row_y    = rfc_pkg::XY_W'(y);
        op.width    = rfc_pkg::EXT_W'(w);
        op.height   = rfc_pkg::EXT_W'(h);
        {op.red, op.green, op.blue} = colour;
        return op;
    endfunction

    // Every field random; callers narrow the ones that matter.
    function automatic canvas_cmd_t random_item(input rfc_pkg::cmd_t c);
        canvas_cmd_t op;
        op = rfc_pkg::IN_DATA_W'({$urandom, $urandom});
        op.command = c;
        return op;
    endfunction

    // Draws are mostly small so that the run stays short; a few span the canvas.
    function automatic canvas_cmd_t random_draw();
        canvas_cmd_t op;
        int          roll;
        op   = random_item(rfc_pkg::CMD_DRAW);
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            op.width  = rfc_pkg::EXT_W'($urandom_range(0, 12));
            op.height = rfc_pkg::EXT_W'($urandom_range(0, 12));
        end
        else if (roll < 97)
        begin
            op.width  = rfc_pkg::EXT_W'($urandom_range(0, 40));
            op.height = rfc_pkg::EXT_W'($urandom_range(0, 40));
        end
        return op;
    endfunction

    // Sends one command and records its expected result once the transfer happens.
    task automatic send_command(input canvas_cmd_t op);
        int gap;
        gap = 0;
        if (drain_each)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0)
                @(posedge clk);
        end
        else if (!steady && $urandom_range(0, 1) == 1)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_to_canvas(op));
    endtask

    // Extremes, clipping, zero sizes, saturation and the spare code, one at a time.
    task automatic test_corner_cases();
        drain_each = 1'b1;
        send_command(make_cmd(rfc_pkg::CMD_READ, 0, 0, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 127, 127, 255, 255, 24'hFFFFFF));
        send_command(make_cmd(rfc_pkg::CMD_NOP, 127, 127, 255, 255, 24'hFFFFFF));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 5, 6, 0, 9, 24'h123456));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 9, 3, 7, 0, 24'h654321));
        send_command(make_cmd(rfc_pkg::CMD_READ, 5, 6, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 127, 127, 1, 1, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 127, 127, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 120, 10, 20, 3, 24'hA55A3C));
        send_command(make_cmd(rfc_pkg::CMD_READ, 0, 11, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 119, 11, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 120, 11, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 127, 12, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 100, 100, 255, 255, 24'h0F0F0F));
        send_command(make_cmd(rfc_pkg::CMD_READ, 127, 127, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_NOP, 0, 0, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_CLEAR, 0, 0, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 127, 12, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 0, 0, 128, 128, 24'h00FF00));
        send_command(make_cmd(rfc_pkg::CMD_READ, 64, 64, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_DRAW, 127, 0, 1, 255, 24'hC3C3C3));
        send_command(make_cmd(rfc_pkg::CMD_READ, 127, 0, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_READ, 0, 127, 0, 0, 24'h000000));
        send_command(make_cmd(rfc_pkg::CMD_CLEAR, 127, 127, 255, 255, 24'hFFFFFF));
        drain_each = 1'b0;
    endtask

    // Random mix; reads mostly probe around the latest rectangle.
    task automatic test_random_mix(input int count);
        canvas_cmd_t op;
        canvas_cmd_t last_draw;
        int          roll;
        last_draw = make_cmd(rfc_pkg::CMD_DRAW, 0, 0, 0, 0, 24'h000000);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                op        = random_draw();
                last_draw = op;
            end
            else if (roll < 93)
            begin
                op = random_item(rfc_pkg::CMD_READ);
                if ($urandom_range(0, 3) != 0)
                begin
                    op.column_x = rfc_pkg::XY_W'(last_draw.column_x
                                                 + $urandom_range(0, last_draw.width));
                    op.row_y    = rfc_pkg::XY_W'(last_draw.row_y
                                                 + $urandom_range(0, last_draw.height));
                end
            end
            else if (roll < 96)
            begin
                op = random_item(rfc_pkg::CMD_CLEAR);
            end
            else
            begin
                op = random_item(rfc_pkg::CMD_NOP);
            end
            send_command(op);
        end
    endtask

    // Draw followed at once by a read inside it, with neither side idling.
    task automatic test_draw_then_read(input int pairs);
        canvas_cmd_t op;
        canvas_cmd_t probe;
        steady = 1'b1;
        for (int n = 0; n < pairs; n++)
        begin
            op        = random_item(rfc_pkg::CMD_DRAW);
            op.width  = rfc_pkg::EXT_W'($urandom_range(1, 6));
            op.height = rfc_pkg::EXT_W'($urandom_range(1, 6));
            send_command(op);
            probe          = random_item(rfc_pkg::CMD_READ);
            probe.column_x = rfc_pkg::XY_W'(op.column_x + $urandom_range(0, op.width - 1));
            probe.row_y    = rfc_pkg::XY_W'(op.row_y + $urandom_range(0, op.height - 1));
            send_command(probe);
        end
        send_command(random_item(rfc_pkg::CMD_CLEAR));
        send_command(make_cmd(rfc_pkg::CMD_READ, 0, 0, 0, 0, 24'h000000));
        steady = 1'b0;
    endtask

    // Result sink: ready most of the time, with random stalls unless steady.
    initial
    begin
        sink_hold = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0 && !steady)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                sink_hold = 0;
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 15)
                    sink_hold = pick_gap();
            end
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        rfc_pkg::res_t got;
        rfc_pkg::res_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            result_count++;
            if (pending_results.size() == 0)
            begin
                log_error($sformatf("result %0d arrived with nothing expected: %h",
                                    result_count, m_tdata));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.pixel_red !== want.pixel_red || got.pixel_green !== want.pixel_green ||
                    got.pixel_blue !== want.pixel_blue || got.used_rows !== want.used_rows ||
                    got.used_columns !== want.used_columns)
                    log_error($sformatf({"result %0d mismatch: expected rgb %h%h%h ",
                                         "rows %0d cols %0d, got rgb %h%h%h rows %0d cols %0d"},
                                        result_count, want.pixel_red, want.pixel_green,
                                        want.pixel_blue, want.used_rows, want.used_columns,
                                        got.pixel_red, got.pixel_green, got.pixel_blue,
                                        got.used_rows, got.used_columns));
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rectangle_fill_canvas");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        steady       = 1'b0;
        drain_each   = 1'b0;
        row_reach    = 0;
        column_reach = 0;
        foreach (canvas_shadow[k])
            canvas_shadow[k] = rfc_pkg::WHITE_PIXEL;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_random_mix(560);
        test_draw_then_read(80);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS rectangle_fill_canvas");
        else
            $display("FAIL rectangle_fill_canvas");
        $finish;
    end

endmodule
